@@ hdl/uer_pkg.sv @@
// Package for the ultrasonic echo ranger: beat payload structs, phase and
// status codes, and fixed field widths.
// No dependencies; used by ultrasonic_echo_ranger_unit.
package uer_pkg;

  // Fixed field widths.
  localparam int unsigned CfgW   = 9;
  localparam int unsigned EtimeW = 15;
  localparam int unsigned CntW   = 16;

  // Ping sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TLOW    = 3'd1,
    PH_THIGH   = 3'd2,
    PH_ARM     = 3'd3,
    PH_WAIT    = 3'd4,
    PH_MEASURE = 3'd5
  } phase_e;

  // Ping result codes.
  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_TOO_LONG      = 2'd1,
    ST_ALREADY_HIGH  = 2'd2,
    ST_NEVER_STARTED = 2'd3
  } status_e;

  // One input beat: one sampled tick.
  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_beat_t;

  // One output beat: pin level and ping result for the tick.
  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    status_e           status;
    logic [EtimeW-1:0] echo_time;
  } out_beat_t;

endpackage

@@ hdl/ultrasonic_echo_ranger_unit.sv @@
// Ultrasonic echo ranger: trigger pulse generator and echo width timer.
// The result for a tick is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle while the output is not stalled; the output register is refilled while drained.
// The result register is the only stage, so a stall holds at most one beat.
// Reset: sequencer idle, tick count zero, range limit at the lesser of MAX_RANGE_CM
// and 500 cm, no result pending.
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned ROUNDTRIP_TICKS_PER_CM = 57,
  parameter int unsigned MAX_RANGE_CM           = 500,
  parameter int unsigned START_WAIT_TICKS       = 5800,
  parameter int unsigned OVERHEAD_TICKS         = 5,
  parameter int unsigned TRIG_LOW_TICKS         = 4,
  parameter int unsigned TRIG_HIGH_TICKS        = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [uer_pkg::CfgW-1:0]  cfg_data_i,
  // Tick input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  uer_pkg::in_beat_t         in_data_i,
  // Result output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output uer_pkg::out_beat_t        out_data_o
);
  import uer_pkg::*;

  // Comparison width covers the tick counter and the rise timeout.
  localparam int unsigned CmpW = CntW + 1;
  localparam int unsigned ResetCm = (MAX_RANGE_CM > 500) ? 500 : MAX_RANGE_CM;
  localparam int unsigned ResetLimit = (ResetCm + 1) * ROUNDTRIP_TICKS_PER_CM;

  logic [CmpW-1:0]   limit_q, limit_d;
  logic [CfgW-1:0]   cfg_cm;
  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   elapsed_q, elapsed_d;
  logic [CntW-1:0]   elapsed_inc;
  logic [CmpW-1:0]   wait_limit;
  logic [CntW-1:0]   etime_full;
  logic              out_valid_q;
  out_beat_t         out_data_q, res_d;
  logic              in_accept;

  // Configuration is always accepted; the limit is recomputed on each write.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i > CfgW'(MAX_RANGE_CM)) begin
      cfg_cm = CfgW'(MAX_RANGE_CM);
    end else begin
      cfg_cm = cfg_data_i;
    end
    limit_d = (CmpW'(cfg_cm) + CmpW'(1)) * CmpW'(ROUNDTRIP_TICKS_PER_CM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CmpW'(ResetLimit);
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= limit_d;
    end
  end

  // A tick is taken whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign elapsed_inc = elapsed_q + CntW'(1);
  assign wait_limit  = limit_q + CmpW'(START_WAIT_TICKS);

  // Echo width less overhead, floored at zero; it is capped to the field where the result is built.
  always_comb begin
    if (elapsed_q > CntW'(OVERHEAD_TICKS)) begin
      etime_full = elapsed_q - CntW'(OVERHEAD_TICKS);
    end else begin
      etime_full = '0;
    end
  end

  // Next phase, tick count and result for the current tick.
  always_comb begin
    phase_d             = phase_q;
    elapsed_d           = elapsed_q;
    res_d.trigger_level = 1'b0;
    res_d.busy_res      = 1'b0;
    res_d.done_res      = 1'b0;
    res_d.status        = ST_OK;
    res_d.echo_time     = '0;
    case (phase_q)
      PH_IDLE: begin
        if (in_data_i.start_request) begin
          if (CntW'(1) >= CntW'(TRIG_LOW_TICKS)) begin
            phase_d   = PH_THIGH;
            elapsed_d = '0;
          end else begin
            phase_d   = PH_TLOW;
            elapsed_d = CntW'(1);
          end
        end
      end
      PH_TLOW: begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= CntW'(TRIG_LOW_TICKS)) begin
          phase_d   = PH_THIGH;
          elapsed_d = '0;
        end
      end
      PH_THIGH: begin
        res_d.trigger_level = 1'b1;
        elapsed_d           = elapsed_inc;
        if (elapsed_inc >= CntW'(TRIG_HIGH_TICKS)) begin
          phase_d   = PH_ARM;
          elapsed_d = '0;
        end
      end
      PH_ARM: begin
        elapsed_d = '0;
        if (in_data_i.echo_level) begin
          res_d.done_res = 1'b1;
          res_d.status   = ST_ALREADY_HIGH;
          phase_d        = PH_IDLE;
        end else begin
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (in_data_i.echo_level) begin
          phase_d   = PH_MEASURE;
          elapsed_d = CntW'(1);
        end else if (CmpW'(elapsed_inc) > wait_limit) begin
          res_d.done_res = 1'b1;
          res_d.status   = ST_NEVER_STARTED;
          phase_d        = PH_IDLE;
          elapsed_d      = '0;
        end else begin
          elapsed_d = elapsed_inc;
        end
      end
      PH_MEASURE: begin
        if (in_data_i.echo_level) begin
          if (CmpW'(elapsed_inc) > limit_q) begin
            res_d.done_res = 1'b1;
            res_d.status   = ST_TOO_LONG;
            phase_d        = PH_IDLE;
            elapsed_d      = '0;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end else begin
          res_d.done_res = 1'b1;
          res_d.status   = ST_OK;
          if (etime_full > CntW'({EtimeW{1'b1}})) begin
            res_d.echo_time = {EtimeW{1'b1}};
          end else begin
            res_d.echo_time = etime_full[EtimeW-1:0];
          end
          phase_d   = PH_IDLE;
          elapsed_d = '0;
        end
      end
      default: begin
        phase_d   = PH_IDLE;
        elapsed_d = '0;
      end
    endcase
    res_d.busy_res = (phase_d != PH_IDLE);
  end

  // Sequencer state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The input side only stalls behind a pending result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // A finished ping always returns the sequencer to idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  // Status and echo time are zero on ticks without a result.
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |->
      out_data_o.status == ST_OK && out_data_o.echo_time == '0)
    else $error("result fields set without done");

  // The trigger pin is only driven high in the middle of a ping.
  a_trigger_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |-> out_data_o.busy_res)
    else $error("trigger high while idle");

endmodule
